[design/setc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and tables for the smooth escape-time colouriser.
// No dependencies.
package setc_pkg;

	localparam int GRADIENT_ENTRIES_DEF = 2048;
	localparam int ITER_BITS_DEF        = 16;
	localparam int RADIUS_FRAC_BITS_DEF = 16;

	localparam logic [17:0] LOG2_099_Q24 = 18'd243262;
	localparam logic [16:0] ONE_Q16      = 17'h10000;
	localparam int          NUM_STOPS    = 6;
	localparam int          POS_SCALE    = 10000;

	typedef struct packed {
		logic [15:0] iter_count;
		logic [23:0] radius_sq;
	} px_in_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [10:0] grad_index;
	} px_out_t;

	// round(2^(-2^-(k+1)) * 65536)
	function automatic logic [15:0] pow_half(input int k);
		case (k)
			0:       return 16'd46341;
			1:       return 16'd55109;
			2:       return 16'd60097;
			3:       return 16'd62757;
			4:       return 16'd64132;
			5:       return 16'd64830;
			6:       return 16'd65182;
			7:       return 16'd65359;
			8:       return 16'd65447;
			9:       return 16'd65492;
			10:      return 16'd65514;
			11:      return 16'd65525;
			12:      return 16'd65530;
			13:      return 16'd65533;
			default: return 16'd65535;
		endcase
	endfunction

	// stop positions in units of 1/10000
	function automatic int stop_pos(input int k);
		case (k)
			0:       return 0;
			1:       return 1600;
			2:       return 4200;
			3:       return 6425;
			4:       return 8575;
			default: return 10000;
		endcase
	endfunction

	function automatic int stop_chan(input int k, input int ch);
		case (k * 3 + ch)
			0:       return 0;
			1:       return 7;
			2:       return 100;
			3:       return 32;
			4:       return 107;
			5:       return 203;
			6:       return 237;
			7:       return 255;
			8:       return 255;
			9:       return 255;
			10:      return 170;
			11:      return 0;
			12:      return 0;
			13:      return 2;
			default: return 0;
		endcase
	endfunction

endpackage

[design/setc_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module setc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/setc_log2.sv]
`timescale 1ns / 1ps
// Pipelined fixed-point log2: leading-one stage then sixteen square-and-halve stages.
// Depends on nothing beyond its parameters.
module setc_log2 #(
	parameter int IN_W   = 24,
	parameter int SIDE_W = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [IN_W-1:0]          in_v,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_valid,
	output logic [$clog2(IN_W)-1:0]  out_top,
	output logic [15:0]              out_frac,
	output logic [SIDE_W-1:0]        out_side
);

	localparam int TW = $clog2(IN_W);

	logic [TW-1:0]     top_c;
	logic [4:0]        sh_c;
	logic [30:0]       m_c;

	logic [16:0]       vld_s;
	logic [30:0]       m_s    [0:16];
	logic [15:0]       frac_s [0:16];
	logic [TW-1:0]     top_s  [0:16];
	logic [SIDE_W-1:0] side_s [0:16];

	always_comb begin
		top_c = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (in_v[i]) top_c = TW'(i);
		end
		sh_c = 5'd30 - 5'(top_c);
		m_c  = 31'(in_v) << sh_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[15:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		m_s[0]    <= m_c;
		frac_s[0] <= '0;
		top_s[0]  <= top_c;
		side_s[0] <= in_side;
	end

	for (genvar k = 0; k < 16; k++) begin : g_sq
		localparam int B = 15 - k;
		logic [61:0] sq;
		logic [31:0] t;
		assign sq = m_s[k] * m_s[k];
		assign t  = sq[61:30];
		always_ff @(posedge clk) begin
			m_s[k+1]    <= t[31] ? t[31:1] : t[30:0];
			frac_s[k+1] <= frac_s[k] | (16'(t[31]) << B);
			top_s[k+1]  <= top_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[16];
	assign out_top   = top_s[16];
	assign out_frac  = frac_s[16];
	assign out_side  = side_s[16];

endmodule

[design/setc_pow.sv]
`timescale 1ns / 1ps
// Pipelined 2^-f for a Q.16 fraction f, one table multiply per stage.
// Depends on setc_pkg (pow_half table).
module setc_pow import setc_pkg::*; #(
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [15:0]       in_frac,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [16:0]       out_p,
	output logic [SIDE_W-1:0] out_side
);

	logic [16:0]       vld_s;
	logic [16:0]       p_s    [0:16];
	logic [15:0]       frac_s [0:16];
	logic [SIDE_W-1:0] side_s [0:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[15:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		p_s[0]    <= ONE_Q16;
		frac_s[0] <= in_frac;
		side_s[0] <= in_side;
	end

	for (genvar k = 0; k < 16; k++) begin : g_mul
		localparam logic [15:0] T = pow_half(k);
		logic [32:0] prod;
		assign prod = p_s[k] * T;
		always_ff @(posedge clk) begin
			p_s[k+1]    <= frac_s[k][15-k] ? prod[32:16] : p_s[k];
			frac_s[k+1] <= frac_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[16];
	assign out_p     = p_s[16];
	assign out_side  = side_s[16];

endmodule

[design/setc_fill.sv]
`timescale 1ns / 1ps
// Gradient table builder: after reset sweeps every entry, interpolates the colour
// stops and divides serially, then writes each entry in turn. Uses setc_pkg.
module setc_fill import setc_pkg::*; #(
	parameter int ENTRIES = GRADIENT_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	output logic                       busy,
	output logic                       we,
	output logic [$clog2(ENTRIES)-1:0] waddr,
	output logic [23:0]                wdata
);

	localparam int IW = $clog2(ENTRIES);
	localparam int XW = 26;

	localparam logic [2:0] ST_SEG  = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]    state_q;
	logic [IW-1:0] i_q;
	logic [2:0]    seg_q;
	logic [2:0]    k_q;
	logic [23:0]   num_q;
	logic [23:0]   den_q;
	logic [31:0]   rem_q [0:2];
	logic [7:0]    qt_q  [0:2];

	logic [XW-1:0] xi_c;
	logic [2:0]    seg_c;
	logic [XW-1:0] num_c;
	logic [23:0]   den_c;

	always_comb begin
		xi_c  = XW'(i_q) * XW'(POS_SCALE);
		seg_c = '0;
		for (int k = 1; k < NUM_STOPS - 1; k++) begin
			if (XW'(stop_pos(k) * ENTRIES) < xi_c) seg_c = seg_c + 3'd1;
		end
		num_c = xi_c - XW'(stop_pos(int'(seg_c)) * ENTRIES);
		den_c = 24'((stop_pos(int'(seg_c) + 1) - stop_pos(int'(seg_c))) * ENTRIES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SEG;
			i_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_SEG: state_q <= ST_MUL;
				ST_MUL: begin
					k_q     <= 3'd7;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					k_q <= k_q - 3'd1;
					if (k_q == 3'd0) state_q <= ST_WR;
				end
				ST_WR: begin
					if (i_q == IW'(ENTRIES - 1)) begin
						state_q <= ST_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_SEG;
					end
				end
				default: state_q <= ST_DONE;
			endcase
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_ch
		logic signed [33:0] v_c;
		logic [31:0]        dsh_c;
		always_comb begin
			v_c = $signed(34'(stop_chan(int'(seg_q), ch))) * $signed({10'b0, den_q})
				+ $signed(34'(stop_chan(int'(seg_q) + 1, ch) - stop_chan(int'(seg_q), ch)))
				* $signed({10'b0, num_q});
			dsh_c = {8'b0, den_q} << k_q;
		end
		always_ff @(posedge clk) begin
			if (state_q == ST_MUL) begin
				rem_q[ch] <= v_c[31:0];
				qt_q[ch]  <= '0;
			end else if (state_q == ST_DIV && rem_q[ch] >= dsh_c) begin
				rem_q[ch]      <= rem_q[ch] - dsh_c;
				qt_q[ch][k_q]  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEG) begin
			seg_q <= seg_c;
			num_q <= num_c[23:0];
			den_q <= den_c;
		end
	end

	assign busy  = (state_q != ST_DONE);
	assign we    = (state_q == ST_WR);
	assign waddr = i_q;
	assign wdata = {qt_q[0], qt_q[1], qt_q[2]};

endmodule

[design/smooth_escape_time_colorizer.sv]
`timescale 1ns / 1ps
// Top level of the smooth escape-time colouriser: log, power and gradient RAM pipeline.
// Depends on setc_pkg, setc_ram, setc_log2, setc_pow, setc_fill.
//
//  channel  | handshake       | payload
//  ---------+-----------------+-------------------------------
//  pixel in | start / busy    | pixel  (iter_count, radius_sq)
//  colour   | strobe          | colour (red, green, blue, grad_index)
//
// One transaction accepted per cycle while busy is low; strobe follows acceptance via
// stage 1, log2 pipe A, stage 2, log2 pipe B (17 stages each), stages 3 and 4, the
// power pipe (17 stages), stages 5 and 6, and the RAM read with stage 7. After reset busy
// stays high while the fill sequencer writes the gradient RAM. Afterwards busy is low for good.
// The receiver cannot stall; every result is shown for one cycle only.
module smooth_escape_time_colorizer import setc_pkg::*; #(
	parameter int GRADIENT_ENTRIES = GRADIENT_ENTRIES_DEF,
	parameter int ITER_BITS        = ITER_BITS_DEF,
	parameter int RADIUS_FRAC_BITS = RADIUS_FRAC_BITS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  px_in_t  pixel,
	output logic    strobe,
	output px_out_t colour
);

	localparam int NB   = (ITER_BITS < 16) ? ITER_BITS : 16;
	localparam int IW   = $clog2(GRADIENT_ENTRIES);
	localparam int SW   = NB + 19;
	localparam int FB   = RADIUS_FRAC_BITS;
	localparam int PW   = 17 + IW;
	localparam int LG_W = 20;
	localparam int LAT  = 58;

	// fill and RAM
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [23:0]   ram_wdata;
	logic [23:0]   ram_rdata;

	setc_fill #(.ENTRIES(GRADIENT_ENTRIES)) u_fill (
		.clk(clk), .arst_n(arst_n), .busy(busy),
		.we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata)
	);

	// stage 1: input capture
	logic          vld_s1;
	logic [NB-1:0] n_s1;
	logic [23:0]   r_s1;
	logic          small_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		n_s1     <= pixel.iter_count[NB-1:0];
		r_s1     <= pixel.radius_sq;
		small_s1 <= ({1'b0, pixel.radius_sq} <= (25'd1 << FB));
	end

	// log2 of radius
	logic          a_vld;
	logic [4:0]    a_top;
	logic [15:0]   a_frac;
	logic [NB:0]   a_side;

	setc_log2 #(.IN_W(24), .SIDE_W(NB + 1)) u_log_a (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s1), .in_v(r_s1),
		.in_side({n_s1, small_s1}), .out_valid(a_vld), .out_top(a_top),
		.out_frac(a_frac), .out_side(a_side)
	);

	// stage 2: L in Q.16
	logic [4:0]      lgi_c;
	logic [LG_W-1:0] lg_c;
	logic            vld_s2;
	logic [LG_W-1:0] lg_s2;
	logic [NB-1:0]   n_s2;
	logic            fmax_s2;

	assign lgi_c = a_top - 5'(FB);
	assign lg_c  = {lgi_c[3:0], a_frac};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= a_vld;
	end

	always_ff @(posedge clk) begin
		lg_s2   <= lg_c;
		n_s2    <= a_side[NB:1];
		fmax_s2 <= a_side[0] || (lg_c == '0);
	end

	// log2 of L
	logic          b_vld;
	logic [4:0]    b_top;
	logic [15:0]   b_frac;
	logic [NB:0]   b_side;

	setc_log2 #(.IN_W(LG_W), .SIDE_W(NB + 1)) u_log_b (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s2), .in_v(lg_s2),
		.in_side({n_s2, fmax_s2}), .out_valid(b_vld), .out_top(b_top),
		.out_frac(b_frac), .out_side(b_side)
	);

	// stage 3: smooth = (n + 18 - top) * 2^16 - frac
	logic [SW-17:0] ip_c;
	logic [SW-1:0]  sm_c;
	logic           vld_s3;
	logic [26:0]    sm_s3;
	logic           fmax_s3;
	logic           fzero_s3;
	logic           sat_s3;

	assign ip_c = (SW-16)'(b_side[NB:1]) + (SW-16)'(18) - (SW-16)'(b_top);
	assign sm_c = {ip_c, 16'h0} - SW'(b_frac);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= b_vld;
	end

	always_ff @(posedge clk) begin
		sm_s3    <= sm_c[26:0];
		fmax_s3  <= b_side[0];
		fzero_s3 <= !b_side[0] && (sm_c[SW-1] || (sm_c == '0));
		sat_s3   <= !sm_c[SW-1] && ((SW+28)'(sm_c) >= ((SW+28)'(1) << 27));
	end

	// stage 4: x = smooth * -log2(0.99)
	logic [44:0] xp_c;
	logic        vld_s4;
	logic [20:0] x_s4;
	logic        fmax_s4;
	logic        fzero_s4;
	logic        sat_s4;

	assign xp_c = sm_s3 * LOG2_099_Q24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		x_s4     <= xp_c[44:24];
		fmax_s4  <= fmax_s3;
		fzero_s4 <= fzero_s3;
		sat_s4   <= sat_s3;
	end

	// 2^-frac(x)
	logic        c_vld;
	logic [16:0] c_p;
	logic [7:0]  c_side;

	setc_pow #(.SIDE_W(8)) u_pow (
		.clk(clk), .arst_n(arst_n), .in_valid(vld_s4), .in_frac(x_s4[15:0]),
		.in_side({x_s4[20:16], fmax_s4, fzero_s4, sat_s4}),
		.out_valid(c_vld), .out_p(c_p), .out_side(c_side)
	);

	// stage 5: integer shift
	logic [4:0]  c_q;
	logic        vld_s5;
	logic [16:0] p_s5;
	logic        fmax_s5;
	logic        fzero_s5;

	assign c_q = c_side[7:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else         vld_s5 <= c_vld;
	end

	always_ff @(posedge clk) begin
		p_s5     <= (c_side[0] || c_q > 5'd16) ? '0 : (c_p >> c_q);
		fmax_s5  <= c_side[2];
		fzero_s5 <= c_side[1];
	end

	// stage 6: index
	logic [PW-1:0] ip6_c;
	logic [IW:0]   raw_c;
	logic          vld_s6;
	logic [IW-1:0] idx_s6;

	assign ip6_c = PW'(ONE_Q16 - p_s5) * PW'(GRADIENT_ENTRIES);
	assign raw_c = ip6_c[PW-1:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else         vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (fmax_s5) begin
			idx_s6 <= IW'(GRADIENT_ENTRIES - 1);
		end else if (fzero_s5) begin
			idx_s6 <= '0;
		end else if (raw_c >= (IW+1)'(GRADIENT_ENTRIES)) begin
			idx_s6 <= IW'(GRADIENT_ENTRIES - 1);
		end else begin
			idx_s6 <= raw_c[IW-1:0];
		end
	end

	setc_ram #(.WIDTH(24), .DEPTH(GRADIENT_ENTRIES)) u_grad (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(idx_s6), .rdata(ram_rdata)
	);

	// stage 7: colour out
	logic          vld_s7;
	logic [IW-1:0] idx_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else         vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		idx_s7 <= idx_s6;
	end

	assign strobe            = vld_s7;
	assign colour.red        = ram_rdata[23:16];
	assign colour.green      = ram_rdata[15:8];
	assign colour.blue       = ram_rdata[7:0];
	assign colour.grad_index = 11'(idx_s7);

	a_fill_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !strobe)
		else $error("result during gradient fill");

	a_fill_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> busy)
		else $error("gradient write after fill");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT strobe)
		else $error("transaction lost in pipeline");

endmodule
